### rtl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
// No dependencies.
package mtep_pkg;

  localparam int unsigned TimeW = 28;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_META    = 3'd1,
    KIND_SYSEX   = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_ERROR   = 3'd5,
    KIND_END     = 3'd6
  } kind_e;

  typedef enum logic [9:0] {
    PH_TAG     = 10'b0000000001,
    PH_LEN     = 10'b0000000010,
    PH_DELTA   = 10'b0000000100,
    PH_STATUS  = 10'b0000001000,
    PH_DATA1   = 10'b0000010000,
    PH_DATA2   = 10'b0000100000,
    PH_SKIP    = 10'b0001000000,
    PH_MTYPE   = 10'b0010000000,
    PH_PLEN    = 10'b0100000000,
    PH_PAYLOAD = 10'b1000000000
  } phase_e;

  localparam logic [7:0] StMeta     = 8'hFF;
  localparam logic [7:0] StSysex    = 8'hF0;
  localparam logic [7:0] StSysexEsc = 8'hF7;

  // One result item as it travels through the queue.
  typedef struct packed {
    kind_e             kind;
    logic [TimeW-1:0]  delta_ticks;
    logic [2:0]        event_type;
    logic [3:0]        channel;
    logic [7:0]        first_data;
    logic [7:0]        second_data;
    logic [1:0]        data_count;
    logic [7:0]        meta_kind;
    logic [TimeW-1:0]  payload_length;
    logic [7:0]        payload_byte;
    logic              last;
    logic              end_of_track;
  } result_t;

  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    tag_byte = 8'h4D;
      2'd1:    tag_byte = 8'h54;
      2'd2:    tag_byte = 8'h72;
      default: tag_byte = 8'h6B;
    endcase
  endfunction

endpackage

### rtl/mtep_front.sv
// Front end: accepts track bytes, runs the parse state machine, builds results.
// Depends on mtep_pkg.
module mtep_front #(
  parameter int unsigned MaxVarlenBytes = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  output logic              byte_ready_o,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mtep_pkg::result_t res_o
);

  localparam int unsigned CntW = $clog2(MaxVarlenBytes + 1);

  mtep_pkg::phase_e phase_q, phase_d;
  logic [1:0]  field_q, field_d;
  logic [31:0] tlen_q, tlen_d, used_q, used_d;
  logic [7:0]  run_q, run_d, cur_q, cur_d, held_q, held_d;
  logic [27:0] delta_q, delta_d, lacc_q, lacc_d, left_q, left_d;
  logic [CntW-1:0] vcnt_q, vcnt_d;
  logic        halt_q, halt_d;

  logic              take;
  logic              emit;
  mtep_pkg::result_t res;
  logic [27:0]       vl_in, vl_acc;
  logic              vl_done;
  logic              finish;

  // Accept a byte whenever the queue can take a possible result.
  assign byte_ready_o = res_ready_i;
  assign take         = byte_valid_i && byte_ready_o;
  assign res_valid_o  = take && emit;
  assign res_o        = res;

  // Shared variable-length quantity step.
  always_comb begin
    vl_in   = (phase_q == mtep_pkg::PH_DELTA) ? delta_q : lacc_q;
    vl_acc  = {vl_in[20:0], byte_i[6:0]};
    vl_done = !byte_i[7] || ({1'b0, vcnt_q} + 1'b1 >= (CntW + 1)'(MaxVarlenBytes));
  end

  always_comb begin
    phase_d = phase_q; field_d = field_q; tlen_d = tlen_q; used_d = used_q;
    run_d = run_q; cur_d = cur_q; held_d = held_q; delta_d = delta_q;
    lacc_d = lacc_q; left_d = left_q; vcnt_d = vcnt_q; halt_d = halt_q;
    emit = 1'b0; finish = 1'b0;
    res = '0;
    if (halt_q) begin
      emit = 1'b1; res.kind = mtep_pkg::KIND_ERROR;
    end else begin
      if (!(phase_q == mtep_pkg::PH_TAG || phase_q == mtep_pkg::PH_LEN) &&
          used_q != 32'hFFFF_FFFF) begin
        used_d = used_q + 32'd1;
      end
      unique case (phase_q)
        mtep_pkg::PH_TAG: begin
          if (byte_i != mtep_pkg::tag_byte(field_q)) begin
            emit = 1'b1; res.kind = mtep_pkg::KIND_ERROR; halt_d = 1'b1;
          end else if (field_q == 2'd3) begin
            field_d = 2'd0; tlen_d = '0; phase_d = mtep_pkg::PH_LEN;
          end else begin
            field_d = field_q + 2'd1;
          end
        end
        mtep_pkg::PH_LEN: begin
          tlen_d = {tlen_q[23:0], byte_i};
          if (field_q != 2'd3) begin
            field_d = field_q + 2'd1;
          end else begin
            field_d = 2'd0; used_d = '0; run_d = '0;
            if (tlen_d == 32'd0) begin
              emit = 1'b1; res.kind = mtep_pkg::KIND_END; res.end_of_track = 1'b1;
              phase_d = mtep_pkg::PH_TAG;
            end else begin
              phase_d = mtep_pkg::PH_DELTA; delta_d = '0; vcnt_d = '0;
            end
          end
        end
        mtep_pkg::PH_DELTA: begin
          delta_d = vl_acc; vcnt_d = vcnt_q + 1'b1;
          if (vl_done) phase_d = mtep_pkg::PH_STATUS;
        end
        mtep_pkg::PH_STATUS: begin
          if (byte_i[7]) begin
            if (byte_i == mtep_pkg::StMeta) begin
              cur_d = byte_i; phase_d = mtep_pkg::PH_MTYPE;
            end else if (byte_i == mtep_pkg::StSysex || byte_i == mtep_pkg::StSysexEsc) begin
              cur_d = byte_i; held_d = '0; lacc_d = '0; vcnt_d = '0;
              phase_d = mtep_pkg::PH_PLEN;
            end else if (byte_i < 8'hF0) begin
              run_d = byte_i; cur_d = byte_i; phase_d = mtep_pkg::PH_DATA1;
            end else begin
              phase_d = mtep_pkg::PH_SKIP;
            end
          end else if (run_q == 8'd0) begin
            emit = 1'b1; res.kind = mtep_pkg::KIND_ERROR; halt_d = 1'b1;
          end else begin
            cur_d = run_q;
            if (run_q[7:4] == 4'hC || run_q[7:4] == 4'hD) begin
              emit = 1'b1; finish = 1'b1;
              res.first_data = byte_i; res.data_count = 2'd1;
            end else begin
              held_d = byte_i; phase_d = mtep_pkg::PH_DATA2;
            end
          end
        end
        mtep_pkg::PH_DATA1: begin
          if (cur_q[7:4] == 4'hC || cur_q[7:4] == 4'hD) begin
            emit = 1'b1; finish = 1'b1;
            res.first_data = byte_i; res.data_count = 2'd1;
          end else begin
            held_d = byte_i; phase_d = mtep_pkg::PH_DATA2;
          end
        end
        mtep_pkg::PH_DATA2: begin
          emit = 1'b1; finish = 1'b1;
          res.first_data = held_q; res.second_data = byte_i; res.data_count = 2'd2;
        end
        mtep_pkg::PH_SKIP: begin
          emit = 1'b1; finish = 1'b1; res.kind = mtep_pkg::KIND_UNKNOWN;
          res.delta_ticks = delta_q;
        end
        mtep_pkg::PH_MTYPE: begin
          held_d = byte_i; lacc_d = '0; vcnt_d = '0; phase_d = mtep_pkg::PH_PLEN;
        end
        mtep_pkg::PH_PLEN: begin
          lacc_d = vl_acc; vcnt_d = vcnt_q + 1'b1;
          if (vl_done) begin
            emit = 1'b1; left_d = vl_acc;
            res.delta_ticks = delta_q; res.payload_length = vl_acc;
            if (cur_q == mtep_pkg::StMeta) begin
              res.kind = mtep_pkg::KIND_META; res.meta_kind = held_q;
            end else begin
              res.kind = mtep_pkg::KIND_SYSEX;
            end
            if (vl_acc == 28'd0) begin
              res.last = 1'b1; finish = 1'b1;
            end else begin
              phase_d = mtep_pkg::PH_PAYLOAD;
            end
          end
        end
        mtep_pkg::PH_PAYLOAD: begin
          emit = 1'b1; res.kind = mtep_pkg::KIND_PAYLOAD;
          res.delta_ticks = delta_q; res.payload_byte = byte_i;
          if (left_q <= 28'd1) begin
            left_d = '0; res.last = 1'b1; finish = 1'b1;
          end else begin
            left_d = left_q - 28'd1;
          end
        end
        default: phase_d = mtep_pkg::PH_TAG;
      endcase
      // Channel event fields come from the status in effect.
      if (emit && res.kind == mtep_pkg::KIND_CHANNEL) begin
        res.delta_ticks = delta_q;
        res.event_type  = 3'(cur_d[6:4]);
        res.channel     = cur_d[3:0];
      end
      // Close the event: end the track or start the next delta.
      if (finish) begin
        if (used_d >= tlen_q) begin
          res.end_of_track = 1'b1; phase_d = mtep_pkg::PH_TAG; field_d = 2'd0;
        end else begin
          phase_d = mtep_pkg::PH_DELTA; delta_d = '0; vcnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mtep_pkg::PH_TAG; field_q <= '0; tlen_q <= '0; used_q <= '0;
      run_q <= '0; cur_q <= '0; held_q <= '0; delta_q <= '0; lacc_q <= '0;
      left_q <= '0; vcnt_q <= '0; halt_q <= 1'b0;
    end else if (take) begin
      phase_q <= phase_d; field_q <= field_d; tlen_q <= tlen_d; used_q <= used_d;
      run_q <= run_d; cur_q <= cur_d; held_q <= held_d; delta_q <= delta_d;
      lacc_q <= lacc_d; left_q <= left_d; vcnt_q <= vcnt_d; halt_q <= halt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared");
  a_halt_errors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (halt_q && take) |-> (res_valid_o && res.kind == mtep_pkg::KIND_ERROR))
    else $error("halted without error");
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase not one-hot");
  a_res_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> take) else $error("result without byte");
`endif

endmodule

### rtl/mtep_queue.sv
// Two-entry result queue between the parser and the output port.
// Depends on mtep_pkg.
module mtep_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  mtep_pkg::result_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output mtep_pkg::result_t rd_data_o
);

  mtep_pkg::result_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // Store pushed items.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0; rptr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost item");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wptr_q == rptr_q)) else $error("empty queue pointers differ");
`endif

endmodule

### rtl/midi_track_event_parser.sv
// Top level of the MIDI track chunk parser: parser front end plus result queue.
// Depends on mtep_pkg, mtep_front, mtep_queue.
//
//   channel  | valid              | ready              | payload
//   input    | data_byte_valid_i  | data_byte_ready_o  | data_byte_i
//   result   | result_valid_o     | result_ready_i     | kind_o .. end_of_track_o
//
// One byte is taken each cycle; a result enters the two-entry queue in the
// same cycle and can leave it in the next cycle at the earliest.
// Bytes stall only while the queue is full. Reset clears the parse state and queue.
module midi_track_event_parser #(
  parameter int unsigned MaxVarlenBytes = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        data_byte_valid_i,
  output logic        data_byte_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [2:0]  kind_o,
  output logic [27:0] delta_ticks_o,
  output logic [2:0]  event_type_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  first_data_o,
  output logic [7:0]  second_data_o,
  output logic [1:0]  data_count_o,
  output logic [7:0]  meta_kind_o,
  output logic [27:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o,
  output logic        end_of_track_o
);

  logic              fr_valid, fr_ready;
  mtep_pkg::result_t fr_data, q_data;

  mtep_front #(.MaxVarlenBytes(MaxVarlenBytes)) u_front (
    .clk_i, .rst_ni,
    .byte_valid_i(data_byte_valid_i), .byte_ready_o(data_byte_ready_o),
    .byte_i(data_byte_i),
    .res_valid_o(fr_valid), .res_ready_i(fr_ready), .res_o(fr_data)
  );

  mtep_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fr_valid), .wr_ready_o(fr_ready), .wr_data_i(fr_data),
    .rd_valid_o(result_valid_o), .rd_ready_i(result_ready_i), .rd_data_o(q_data)
  );

  assign kind_o           = q_data.kind;
  assign delta_ticks_o    = q_data.delta_ticks;
  assign event_type_o     = q_data.event_type;
  assign channel_o        = q_data.channel;
  assign first_data_o     = q_data.first_data;
  assign second_data_o    = q_data.second_data;
  assign data_count_o     = q_data.data_count;
  assign meta_kind_o      = q_data.meta_kind;
  assign payload_length_o = q_data.payload_length;
  assign payload_byte_o   = q_data.payload_byte;
  assign last_o           = q_data.last;
  assign end_of_track_o   = q_data.end_of_track;

endmodule
